### src/dtd_pkg.sv
// Shared types, constants and the branch delay table of the time deinterleaver.
// No dependencies; imported by every module of the block.
package dtd_pkg;

    localparam int SOFT_W             = 16;
    localparam int FRAME_LEN_W        = 15;
    localparam int SLOT_W             = 4;
    localparam int WARM_W             = 5;
    localparam int WARMUP_FRAMES      = 16;
    localparam int DEF_MAX_FRAME_BITS = 16384;
    localparam int RST_FRAME_BITS     = 16384;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        slot_t wr_slot;
        slot_t rd_slot;
        logic  bypass;
        logic  last;
        logic  emit;
    } dtd_step_t;

    function automatic slot_t branch_delay(input slot_t branch);
        slot_t d;
        case (branch)
            4'd0:    d = 4'd15;
            4'd1:    d = 4'd7;
            4'd2:    d = 4'd11;
            4'd3:    d = 4'd3;
            4'd4:    d = 4'd13;
            4'd5:    d = 4'd5;
            4'd6:    d = 4'd9;
            4'd7:    d = 4'd1;
            4'd8:    d = 4'd14;
            4'd9:    d = 4'd6;
            4'd10:   d = 4'd10;
            4'd11:   d = 4'd2;
            4'd12:   d = 4'd12;
            4'd13:   d = 4'd4;
            4'd14:   d = 4'd8;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

### src/dab_time_deinterleaver_unit.sv
// Top level of the 16-branch convolutional time deinterleaver.
// Depends on dtd_pkg, dtd_ctrl and dtd_hist.
//
//  channel | direction | handshake              | payload
//  s_      | in        | s_tvalid / s_tready    | s_tdata[15:0] soft_bit
//  m_      | out       | m_tvalid / m_tready    | m_tdata[15:0] delayed_bit, m_tlast
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_data[14:0] frame_length
//
// One request accepted per cycle while s_tready is high; a result passes the read stage, then the output stage.
// Rate is set by the single history memory port pair: one write and one read a cycle.
// The first 16 frames after reset give no results.
// Reset clears counters and valid flags; the history memory is not cleared.
// A stall on m_ holds the output and read stages; s_tready drops when both are full and m_tready is low.
module dab_time_deinterleaver_unit
    import dtd_pkg::*;
#(
    parameter int MAX_FRAME_BITS = DEF_MAX_FRAME_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [SOFT_W-1:0]      s_tdata,    // [15:0] soft_bit
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [SOFT_W-1:0]      m_tdata,    // [15:0] delayed_bit
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [FRAME_LEN_W-1:0] cfg_data    // [14:0] frame_length
);

    localparam int POS_W = $clog2(MAX_FRAME_BITS);

    logic              accept;
    logic              adv;
    logic [POS_W-1:0]  pos;
    dtd_step_t         step;
    logic [SOFT_W-1:0] rd_data;

    logic              v1_reg, v1_next;
    logic              bypass1_reg, last1_reg, emit1_reg;
    logic [SOFT_W-1:0] soft1_reg;
    logic              ov_reg, ov_next;
    logic [SOFT_W-1:0] obit_reg;
    logic              olast_reg;

    assign cfg_ready = 1'b1;
    assign adv       = !ov_reg || m_tready;
    assign s_tready  = !v1_reg || adv;
    assign accept    = s_tvalid && s_tready;

    dtd_ctrl #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS),
        .POS_W          (POS_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pos       (pos),
        .step      (step)
    );

    dtd_hist #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS),
        .POS_W          (POS_W)
    ) u_hist (
        .clk     (clk),
        .en      (accept),
        .pos     (pos),
        .wr_slot (step.wr_slot),
        .rd_slot (step.rd_slot),
        .wr_data (s_tdata),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (accept)
            v1_next = 1'b1;
        else if (adv)
            v1_next = 1'b0;
        else
            v1_next = v1_reg;
        ov_next = adv ? (v1_reg && emit1_reg) : ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            soft1_reg   <= s_tdata;
            bypass1_reg <= step.bypass;
            last1_reg   <= step.last;
            emit1_reg   <= step.emit;
        end
        if (adv && v1_reg)
        begin
            obit_reg  <= bypass1_reg ? soft1_reg : rd_data;
            olast_reg <= last1_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = obit_reg;
    assign m_tlast  = olast_reg;

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && ov_reg && !m_tready |-> !accept)
        else $error("request accepted into full pipeline");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && emit1_reg && adv |=> m_tvalid)
        else $error("emitting request lost");
    a_warmup_silent: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !emit1_reg && adv |=> !m_tvalid)
        else $error("warm-up request produced a result");
`endif

endmodule

### src/dtd_ctrl.sv
// Frame position, frame slot and warm-up counters plus the frame length register.
// Depends on dtd_pkg.
module dtd_ctrl
    import dtd_pkg::*;
#(
    parameter int MAX_FRAME_BITS = DEF_MAX_FRAME_BITS,
    parameter int POS_W          = $clog2(MAX_FRAME_BITS)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [FRAME_LEN_W-1:0] cfg_data,
    input  logic                   accept,
    output logic [POS_W-1:0]       pos,
    output dtd_step_t              step
);

    localparam int RST_LEN = (RST_FRAME_BITS > MAX_FRAME_BITS) ? MAX_FRAME_BITS
                                                                : RST_FRAME_BITS;
    localparam logic [POS_W-1:0] RST_LM1 = POS_W'(RST_LEN - 1);
    localparam logic [POS_W-1:0] MAX_LM1 = POS_W'(MAX_FRAME_BITS - 1);
    localparam logic [FRAME_LEN_W-1:0] MAX_LEN = FRAME_LEN_W'(MAX_FRAME_BITS);
    localparam logic [WARM_W-1:0] WARM_DONE = WARM_W'(WARMUP_FRAMES);

    logic [POS_W-1:0]  lm1_reg, lm1_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    slot_t             slot_reg, slot_next;
    logic [WARM_W-1:0] warm_reg, warm_next;
    logic              last;
    slot_t             rd_slot;

    always_comb
    begin
        lm1_next = lm1_reg;
        if (cfg_valid)
        begin
            if (cfg_data == '0)
                lm1_next = '0;
            else if (cfg_data > MAX_LEN)
                lm1_next = MAX_LM1;
            else
                lm1_next = POS_W'(cfg_data - FRAME_LEN_W'(1));
        end
    end

    assign last    = (pos_reg >= lm1_reg);
    assign pos     = last ? lm1_reg : pos_reg;
    assign rd_slot = slot_reg - branch_delay(pos[SLOT_W-1:0]);

    assign step.wr_slot = slot_reg;
    assign step.rd_slot = rd_slot;
    assign step.bypass  = (branch_delay(pos[SLOT_W-1:0]) == '0);
    assign step.last    = last;
    assign step.emit    = (warm_reg == WARM_DONE);

    always_comb
    begin
        pos_next  = pos_reg;
        slot_next = slot_reg;
        warm_next = warm_reg;
        if (accept)
        begin
            if (last)
            begin
                pos_next  = '0;
                slot_next = slot_reg + slot_t'(1);
                if (warm_reg != WARM_DONE)
                    warm_next = warm_reg + WARM_W'(1);
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lm1_reg  <= RST_LM1;
            pos_reg  <= '0;
            slot_reg <= '0;
            warm_reg <= '0;
        end
        else
        begin
            lm1_reg  <= lm1_next;
            pos_reg  <= pos_next;
            slot_reg <= slot_next;
            warm_reg <= warm_next;
        end
    end

`ifndef SYNTH
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> pos_reg == '0 && slot_reg == $past(slot_reg) + slot_t'(1))
        else $error("position did not wrap at frame end");
    a_pos_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last |=> pos_reg == $past(pos_reg) + POS_W'(1)
                            && slot_reg == $past(slot_reg))
        else $error("position did not advance");
    a_warm_sat: assert property (@(posedge clk) disable iff (!rst_n)
        warm_reg == WARM_DONE |=> warm_reg == WARM_DONE)
        else $error("warm-up count left saturation");
    a_bypass_slot: assert property (@(posedge clk) disable iff (!rst_n)
        step.bypass |-> step.rd_slot == step.wr_slot)
        else $error("zero-delay branch reads another slot");
`endif

endmodule

### src/dtd_hist.sv
// History memory: one write and one registered read per accepted request.
// Depends on dtd_pkg.
module dtd_hist
    import dtd_pkg::*;
#(
    parameter int MAX_FRAME_BITS = DEF_MAX_FRAME_BITS,
    parameter int POS_W          = $clog2(MAX_FRAME_BITS)
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [POS_W-1:0]  pos,
    input  slot_t             wr_slot,
    input  slot_t             rd_slot,
    input  logic [SOFT_W-1:0] wr_data,
    output logic [SOFT_W-1:0] rd_data
);

    localparam int DEPTH = MAX_FRAME_BITS * (2 ** SLOT_W);

    logic [SOFT_W-1:0] mem [DEPTH];
    logic [SOFT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mem[{pos, wr_slot}] <= wr_data;
            rd_data_reg         <= mem[{pos, rd_slot}];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
